[hw/rtl/rbsi_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Rule bytecode stack interpreter package
// Shared constants and types: opcodes, host commands, decoder modes, result
// kinds and error codes.
// ============================================================================

package rbsi_pkg;

    localparam int VAR_COUNT_DEF   = 256;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] OP_BASE = 8'he0;
    localparam logic [7:0] OP_LDR  = OP_BASE + 8'd0;
    localparam logic [7:0] OP_SUB  = OP_BASE + 8'd1;
    localparam logic [7:0] OP_INE  = OP_BASE + 8'd2;
    localparam logic [7:0] OP_POP  = OP_BASE + 8'd3;
    localparam logic [7:0] OP_INC  = OP_BASE + 8'd4;
    localparam logic [7:0] OP_STR  = OP_BASE + 8'd5;
    localparam logic [7:0] OP_END  = OP_BASE + 8'd7;
    localparam logic [7:0] OP_IMM  = OP_BASE + 8'd8;

    localparam logic [1:0] CMD_PROG  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPCODE  = 2'd1,
        MODE_OPERAND = 2'd2,
        MODE_SKIP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_STORED = 2'd0,
        KIND_ENDED  = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNDER   = 2'd1,
        ERR_OVER    = 2'd2,
        ERR_UNKNOWN = 2'd3
    } t_err;

endpackage

[hw/rtl/rule_bytecode_stack_interpreter.sv]
`timescale 1ns / 1ps
// ============================================================================
// Rule bytecode stack interpreter
// Decodes rule bytecode one byte per transfer on an 8-bit stack machine and
// serves host reads and writes of the variable store.
// ============================================================================
// The block takes one item per clock cycle while o_stall is low and returns its
// result, if any, from the execute stage through an output register. An item
// is accepted into the execute stage while the variable store and the stack
// memory are read; the execute stage modifies the stack top and writes both
// memories back. The last variable write is forwarded to the next read.
// Per-entry valid bits make the variable store read as zero after reset, so no
// clearing pass runs. The input side stalls only when the execute stage holds
// a result and the output register is full and stalled.

module rule_bytecode_stack_interpreter #(
    parameter int VAR_COUNT   = rbsi_pkg::VAR_COUNT_DEF,
    parameter int STACK_DEPTH = rbsi_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_code_byte,
    input  logic       i_rule_start,
    input  logic [7:0] i_var_index,
    input  logic [7:0] i_var_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_out_index,
    output logic [7:0] o_out_value,
    output logic [1:0] o_error_code
);
    import rbsi_pkg::*;

    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [8:0]    VAR_LIM   = 9'(VAR_COUNT);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);
    localparam logic [CW-1:0] CNT_TWO   = CW'(2);
    localparam logic [CW-1:0] CNT_FULL  = CW'(STACK_DEPTH);

    logic [7:0]           r_var_mem [VAR_COUNT];
    logic [VAR_COUNT-1:0] r_var_vld;
    logic [7:0]           r_stk_mem [STACK_DEPTH];

    logic          r_s1_valid;
    logic [1:0]    r_cmd;
    logic [7:0]    r_byte;
    logic          r_start;
    logic [7:0]    r_vidx;
    logic [7:0]    r_vval;

    logic [7:0]    r_var_q;
    logic          r_rd_vld;
    logic          r_rd_inr;
    logic [VW-1:0] r_rd_addr;
    logic [7:0]    r_sec;

    logic          r_byp_vld;
    logic [VW-1:0] r_byp_addr;
    logic [7:0]    r_byp_data;

    t_mode         r_mode;
    t_mode         n_mode;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_tos;
    logic [7:0]    n_tos;
    logic [3:0]    r_pend;
    logic [3:0]    n_pend;
    logic [7:0]    r_skip;
    logic [7:0]    n_skip;

    logic          r_out_valid;
    t_kind         r_out_kind;
    logic [7:0]    r_out_idx;
    logic [7:0]    r_out_val;
    t_err          r_out_err;

    logic          accept;
    logic          s1_go;
    logic          out_free;
    logic          prog_byte;
    logic          s1_fail;
    t_err          s1_err;
    logic          s1_res;
    t_kind         res_kind;
    logic [7:0]    res_idx;
    logic [7:0]    res_val;
    t_err          res_err;
    logic          var_we;
    logic [VW-1:0] var_wa;
    logic [7:0]    var_wd;
    logic          stk_we;
    logic [SW-1:0] stk_wa;
    logic [7:0]    stk_wd;
    logic [7:0]    var_rd;
    logic [7:0]    pend_op;
    logic [7:0]    skip_dec;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] stk_ra_full;
    logic [7:0]    rd_addr_full;
    logic          rd_inr;
    logic          vidx_inr;
    logic          byte_inr;
    logic          cnt_lt1;
    logic          cnt_lt2;
    logic          cnt_full;

    // Handshake and pipeline control.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_s1_valid && (!s1_res || out_free);
    assign o_stall  = r_s1_valid && !s1_go;
    assign accept   = i_valid && !o_stall;

    assign rd_addr_full = (i_cmd == CMD_READ) ? i_var_index : i_code_byte;
    assign rd_inr       = {1'b0, rd_addr_full} < VAR_LIM;
    assign vidx_inr     = {1'b0, r_vidx} < VAR_LIM;
    assign byte_inr     = {1'b0, r_byte} < VAR_LIM;
    assign stk_ra_full  = n_count - CNT_TWO;

    assign prog_byte = r_s1_valid && (r_cmd == CMD_PROG) && !r_start;
    assign pend_op   = OP_BASE | {4'b0000, r_pend};
    assign cnt_lt1   = r_count < CNT_ONE;
    assign cnt_lt2   = r_count < CNT_TWO;
    assign cnt_full  = r_count >= CNT_FULL;
    assign cnt_dec   = r_count - CNT_ONE;
    assign skip_dec  = (r_skip == 8'd0) ? 8'd0 : r_skip - 8'd1;

    always_comb begin
        if (!r_rd_inr) begin
            var_rd = 8'd0;
        end else if (r_byp_vld && (r_byp_addr == r_rd_addr)) begin
            var_rd = r_byp_data;
        end else if (r_rd_vld) begin
            var_rd = r_var_q;
        end else begin
            var_rd = 8'd0;
        end
    end

    // Error detection for the byte in the execute stage.
    always_comb begin
        s1_fail = 1'b0;
        s1_err  = ERR_NONE;
        if (prog_byte) begin
            case (r_mode)
                MODE_OPCODE: begin
                    case (r_byte)
                        OP_LDR, OP_INE, OP_STR, OP_IMM, OP_END: begin
                        end
                        OP_SUB: begin
                            if (cnt_lt2) begin
                                s1_fail = 1'b1;
                                s1_err  = ERR_UNDER;
                            end
                        end
                        OP_INC, OP_POP: begin
                            if (cnt_lt1) begin
                                s1_fail = 1'b1;
                                s1_err  = ERR_UNDER;
                            end
                        end
                        default: begin
                            s1_fail = 1'b1;
                            s1_err  = ERR_UNKNOWN;
                        end
                    endcase
                end
                MODE_OPERAND: begin
                    case (pend_op)
                        OP_IMM, OP_LDR: begin
                            if (cnt_full) begin
                                s1_fail = 1'b1;
                                s1_err  = ERR_OVER;
                            end
                        end
                        OP_STR, OP_INE: begin
                            if (cnt_lt1) begin
                                s1_fail = 1'b1;
                                s1_err  = ERR_UNDER;
                            end
                        end
                        default: begin
                            s1_fail = 1'b1;
                            s1_err  = ERR_UNKNOWN;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Decoder next state.
    always_comb begin
        n_mode = r_mode;
        if (r_s1_valid && (r_cmd == CMD_PROG)) begin
            if (r_start) begin
                n_mode = MODE_OPCODE;
            end else if (s1_fail) begin
                n_mode = MODE_IDLE;
            end else begin
                case (r_mode)
                    MODE_OPCODE: begin
                        case (r_byte)
                            OP_LDR, OP_INE, OP_STR, OP_IMM: n_mode = MODE_OPERAND;
                            OP_END:                         n_mode = MODE_IDLE;
                            default:                        n_mode = MODE_OPCODE;
                        endcase
                    end
                    MODE_OPERAND: begin
                        if ((pend_op == OP_INE) && (r_tos == 8'd0) && (r_byte != 8'd0)) begin
                            n_mode = MODE_SKIP;
                        end else begin
                            n_mode = MODE_OPCODE;
                        end
                    end
                    MODE_SKIP: begin
                        if (skip_dec == 8'd0) begin
                            n_mode = MODE_OPCODE;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // Execute stage datapath and results.
    always_comb begin
        n_count  = r_count;
        n_tos    = r_tos;
        n_skip   = r_skip;
        n_pend   = r_pend;
        s1_res   = 1'b0;
        res_kind = KIND_STORED;
        res_idx  = 8'd0;
        res_val  = 8'd0;
        res_err  = ERR_NONE;
        var_we   = 1'b0;
        var_wa   = r_vidx[VW-1:0];
        var_wd   = r_vval;
        stk_we   = 1'b0;
        stk_wa   = cnt_dec[SW-1:0];
        stk_wd   = r_tos;
        if (r_s1_valid) begin
            case (r_cmd)
                CMD_WRITE: begin
                    var_we = vidx_inr;
                end
                CMD_READ: begin
                    s1_res   = 1'b1;
                    res_kind = KIND_READ;
                    res_idx  = r_vidx;
                    res_val  = var_rd;
                end
                CMD_PROG: begin
                    if (r_start) begin
                        n_count = '0;
                        n_skip  = 8'd0;
                    end else if (s1_fail) begin
                        s1_res   = 1'b1;
                        res_kind = KIND_ERROR;
                        res_err  = s1_err;
                    end else begin
                        case (r_mode)
                            MODE_OPCODE: begin
                                case (r_byte)
                                    OP_LDR, OP_INE, OP_STR, OP_IMM: begin
                                        n_pend = r_byte[3:0];
                                    end
                                    OP_SUB: begin
                                        n_tos  = r_sec - r_tos;
                                        stk_we = 1'b1;
                                        stk_wd = r_sec - r_tos;
                                    end
                                    OP_INC: begin
                                        n_tos  = r_tos + 8'd1;
                                        stk_we = 1'b1;
                                        stk_wd = r_tos + 8'd1;
                                    end
                                    OP_POP: begin
                                        n_count = cnt_dec;
                                        n_tos   = r_sec;
                                    end
                                    OP_END: begin
                                        s1_res   = 1'b1;
                                        res_kind = KIND_ENDED;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            MODE_OPERAND: begin
                                case (pend_op)
                                    OP_IMM, OP_LDR: begin
                                        n_tos   = (pend_op == OP_IMM) ? r_byte : var_rd;
                                        n_count = r_count + CNT_ONE;
                                        stk_we  = 1'b1;
                                        stk_wa  = r_count[SW-1:0];
                                        stk_wd  = (pend_op == OP_IMM) ? r_byte : var_rd;
                                    end
                                    OP_STR: begin
                                        var_we   = byte_inr;
                                        var_wa   = r_byte[VW-1:0];
                                        var_wd   = r_tos;
                                        s1_res   = 1'b1;
                                        res_kind = KIND_STORED;
                                        res_idx  = r_byte;
                                        res_val  = r_tos;
                                    end
                                    OP_INE: begin
                                        if ((r_tos == 8'd0) && (r_byte != 8'd0)) begin
                                            n_skip = r_byte;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            MODE_SKIP: begin
                                n_skip = skip_dec;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Variable store and stack memory.
    always_ff @(posedge i_clk) begin
        if (var_we && s1_go) begin
            r_var_mem[var_wa] <= var_wd;
        end
        if (accept) begin
            r_var_q <= r_var_mem[rd_addr_full[VW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we && s1_go) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        if (accept) begin
            r_sec <= r_stk_mem[stk_ra_full[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_vld <= '0;
            r_byp_vld <= 1'b0;
        end else if (var_we && s1_go) begin
            r_var_vld[var_wa] <= 1'b1;
            r_byp_vld         <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (var_we && s1_go) begin
            r_byp_addr <= var_wa;
            r_byp_data <= var_wd;
        end
        if (accept) begin
            r_cmd     <= i_cmd;
            r_byte    <= i_code_byte;
            r_start   <= i_rule_start;
            r_vidx    <= i_var_index;
            r_vval    <= i_var_value;
            r_rd_inr  <= rd_inr;
            r_rd_addr <= rd_addr_full[VW-1:0];
            r_rd_vld  <= r_var_vld[rd_addr_full[VW-1:0]];
        end
        if (s1_go) begin
            r_tos <= n_tos;
        end
        if (s1_go && s1_res) begin
            r_out_kind <= res_kind;
            r_out_idx  <= res_idx;
            r_out_val  <= res_val;
            r_out_err  <= res_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_count     <= '0;
            r_pend      <= 4'd0;
            r_skip      <= 8'd0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && s1_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_go) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_pend  <= n_pend;
                r_skip  <= n_skip;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_out_index   = r_out_idx;
    assign o_out_value   = r_out_val;
    assign o_error_code  = r_out_err;

endmodule
